FILE: design/tbce_pkg.sv
// shared types and constants for the text buffer cursor editor
package tbce_pkg;

    localparam logic [2:0] ACT_LEFT   = 3'd0;
    localparam logic [2:0] ACT_RIGHT  = 3'd1;
    localparam logic [2:0] ACT_INSERT = 3'd2;
    localparam logic [2:0] ACT_CUT    = 3'd3;
    localparam logic [2:0] ACT_COPY   = 3'd4;
    localparam logic [2:0] ACT_PASTE  = 3'd5;
    localparam logic [2:0] ACT_READ   = 3'd6;

    // datapath operation selected by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LATCH     = 4'd1;  // capture command word, compute plan
    localparam logic [3:0] OP_MOVE      = 4'd2;  // left/right/insert-bookkeeping
    localparam logic [3:0] OP_SHR_RD    = 4'd3;  // issue read for right shift
    localparam logic [3:0] OP_SHR_WR    = 4'd4;  // write shifted char
    localparam logic [3:0] OP_INS_WR    = 4'd5;  // write inserted char
    localparam logic [3:0] OP_GRAB_RD   = 4'd6;  // read text for clipboard
    localparam logic [3:0] OP_GRAB_WR   = 4'd7;  // write clipboard
    localparam logic [3:0] OP_SHL_RD    = 4'd8;  // read for left shift
    localparam logic [3:0] OP_SHL_WR    = 4'd9;  // write for left shift
    localparam logic [3:0] OP_PST_RD    = 4'd10; // read clipboard
    localparam logic [3:0] OP_PST_WR    = 4'd11; // write pasted char
    localparam logic [3:0] OP_READ_RD   = 4'd12; // read for read command
    localparam logic [3:0] OP_FINISH    = 4'd13; // commit lengths, build result

    typedef struct packed {
        logic [3:0] op;
    } tbce_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       loop_done;   // current step counter reached its end
        logic       do_shift;    // shift phase needed
        logic       do_copy;     // copy/grab phase needed
    } tbce_status_t;

endpackage

FILE: design/tbce_ctrl.sv
// command sequencer for the text buffer cursor editor
module tbce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  tbce_pkg::tbce_status_t st,
    input  logic                  res_taken,
    output tbce_pkg::tbce_cmd_t   cmd,
    output logic                  busy,
    output logic                  res_valid
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PLAN    = 4'd1;
    localparam logic [3:0] S_SHR_RD  = 4'd2;
    localparam logic [3:0] S_SHR_WR  = 4'd3;
    localparam logic [3:0] S_INS     = 4'd4;
    localparam logic [3:0] S_GRB_RD  = 4'd5;
    localparam logic [3:0] S_GRB_WR  = 4'd6;
    localparam logic [3:0] S_SHL_RD  = 4'd7;
    localparam logic [3:0] S_SHL_WR  = 4'd8;
    localparam logic [3:0] S_PST_RD  = 4'd9;
    localparam logic [3:0] S_PST_WR  = 4'd10;
    localparam logic [3:0] S_RD      = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = tbce_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd.op     = tbce_pkg::OP_LATCH;
                    state_next = S_PLAN;
                end
            end
            S_PLAN: begin
                case (st.action)
                    tbce_pkg::ACT_INSERT: state_next = st.do_shift ? S_SHR_RD :
                                                      (st.do_copy ? S_INS : S_FIN);
                    tbce_pkg::ACT_PASTE:  state_next = st.do_shift ? S_SHR_RD :
                                                      (st.do_copy ? S_PST_RD : S_FIN);
                    tbce_pkg::ACT_CUT,
                    tbce_pkg::ACT_COPY:   state_next = st.do_copy ? S_GRB_RD : S_FIN;
                    tbce_pkg::ACT_READ:   state_next = S_RD;
                    default:              state_next = S_FIN;
                endcase
            end
            S_SHR_RD: begin
                cmd.op     = tbce_pkg::OP_SHR_RD;
                state_next = S_SHR_WR;
            end
            S_SHR_WR: begin
                cmd.op = tbce_pkg::OP_SHR_WR;
                if (!st.loop_done) begin
                    state_next = S_SHR_RD;
                end else if (st.action == tbce_pkg::ACT_INSERT) begin
                    state_next = S_INS;
                end else begin
                    state_next = S_PST_RD;
                end
            end
            S_INS: begin
                cmd.op     = tbce_pkg::OP_INS_WR;
                state_next = S_FIN;
            end
            S_PST_RD: begin
                cmd.op     = tbce_pkg::OP_PST_RD;
                state_next = S_PST_WR;
            end
            S_PST_WR: begin
                cmd.op     = tbce_pkg::OP_PST_WR;
                state_next = st.loop_done ? S_FIN : S_PST_RD;
            end
            S_GRB_RD: begin
                cmd.op     = tbce_pkg::OP_GRAB_RD;
                state_next = S_GRB_WR;
            end
            S_GRB_WR: begin
                cmd.op = tbce_pkg::OP_GRAB_WR;
                if (!st.loop_done) begin
                    state_next = S_GRB_RD;
                end else if (st.action == tbce_pkg::ACT_CUT && st.do_shift) begin
                    state_next = S_SHL_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_SHL_RD: begin
                cmd.op     = tbce_pkg::OP_SHL_RD;
                state_next = S_SHL_WR;
            end
            S_SHL_WR: begin
                cmd.op     = tbce_pkg::OP_SHL_WR;
                state_next = st.loop_done ? S_FIN : S_SHL_RD;
            end
            S_RD: begin
                cmd.op     = tbce_pkg::OP_READ_RD;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.op     = tbce_pkg::OP_FINISH;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (res_taken) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_OUT);

endmodule

FILE: design/tbce_datapath.sv
// text and clipboard stores, lengths, cursor and step counter
module tbce_datapath #(
    parameter int TEXT_DEPTH = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tbce_pkg::tbce_cmd_t    cmd,
    input  logic [2:0]             action,
    input  logic [7:0]             char_in,
    input  logic [8:0]             count,
    input  logic [7:0]             position,
    output tbce_pkg::tbce_status_t st,
    output logic [7:0]             char_out,
    output logic [8:0]             text_length,
    output logic [8:0]             cursor_pos,
    output logic [8:0]             clip_length,
    output logic                   overflow
);

    localparam int AW = $clog2(TEXT_DEPTH);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(TEXT_DEPTH);

    logic [7:0] text_mem [TEXT_DEPTH];
    logic [7:0] clip_mem [TEXT_DEPTH];

    logic [LW-1:0] tlen_reg, cur_reg, clen_reg;
    logic [2:0]    act_reg;
    logic [7:0]    ch_reg;
    logic [7:0]    pos_reg;
    logic [LW-1:0] n_reg;     // chars to move in the copy/paste phase
    logic [LW-1:0] tail_reg;  // chars to shift
    logic [LW-1:0] i_reg;     // step counter
    logic [LW-1:0] lim_reg;   // step limit of current loop
    logic          ovf_reg;
    logic [7:0]    rd_reg;
    logic [7:0]    cout_reg;
    logic          ph_reg;    // 0: shift/grab phase, 1: second phase

    logic [LW-1:0] avail, take, room, pn, last_i;
    logic [AW-1:0] ra, wa;

    assign avail  = tlen_reg - cur_reg;
    assign take   = ({1'b0, count} > LW'(avail)) ? avail : LW'(count);
    assign room   = DEPTH_L - tlen_reg;
    assign pn     = (clen_reg > room) ? room : clen_reg;
    assign last_i = lim_reg - 1'b1;

    // step address generation
    always_comb begin
        ra = '0;
        wa = '0;
        case (cmd.op)
            tbce_pkg::OP_SHR_RD, tbce_pkg::OP_SHR_WR: begin
                // shift right from the end downward
                ra = AW'(tlen_reg - 1'b1 - i_reg);
                wa = AW'(tlen_reg - 1'b1 - i_reg + n_reg);
            end
            tbce_pkg::OP_GRAB_RD: ra = AW'(cur_reg + i_reg);
            tbce_pkg::OP_GRAB_WR: wa = AW'(i_reg);
            tbce_pkg::OP_SHL_RD, tbce_pkg::OP_SHL_WR: begin
                ra = AW'(cur_reg + n_reg + i_reg);
                wa = AW'(cur_reg + i_reg);
            end
            tbce_pkg::OP_PST_RD: ra = AW'(i_reg);
            tbce_pkg::OP_PST_WR: wa = AW'(cur_reg + i_reg);
            tbce_pkg::OP_INS_WR: wa = AW'(cur_reg);
            tbce_pkg::OP_READ_RD: ra = AW'(pos_reg);
            default: begin
                ra = '0;
                wa = '0;
            end
        endcase
    end

    // memories: one read and one write per cycle, registered read data
    always_ff @(posedge aclk) begin
        if (cmd.op == tbce_pkg::OP_PST_RD) begin
            rd_reg <= clip_mem[ra];
        end else begin
            rd_reg <= text_mem[ra];
        end
        if (cmd.op == tbce_pkg::OP_SHR_WR || cmd.op == tbce_pkg::OP_SHL_WR
            || cmd.op == tbce_pkg::OP_PST_WR) begin
            text_mem[wa] <= rd_reg;
        end else if (cmd.op == tbce_pkg::OP_INS_WR) begin
            text_mem[wa] <= ch_reg;
        end
        if (cmd.op == tbce_pkg::OP_GRAB_WR) begin
            clip_mem[wa] <= rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlen_reg <= '0;
            cur_reg  <= '0;
            clen_reg <= '0;
            ovf_reg  <= 1'b0;
            act_reg  <= 3'd7;
            i_reg    <= '0;
            ph_reg   <= 1'b0;
        end else begin
            case (cmd.op)
                tbce_pkg::OP_LATCH: begin
                    act_reg  <= action;
                    ch_reg   <= char_in;
                    pos_reg  <= position;
                    i_reg    <= '0;
                    ph_reg   <= 1'b0;
                    ovf_reg  <= 1'b0;
                    cout_reg <= '0;
                    case (action)
                        tbce_pkg::ACT_INSERT: begin
                            ovf_reg  <= (tlen_reg >= DEPTH_L);
                            n_reg    <= LW'(1);
                            tail_reg <= (tlen_reg >= DEPTH_L) ? '0 : avail;
                            lim_reg  <= avail;
                        end
                        tbce_pkg::ACT_PASTE: begin
                            ovf_reg  <= (clen_reg > room);
                            n_reg    <= pn;
                            tail_reg <= (pn == '0) ? '0 : avail;
                            // no tail to shift: the paste loop runs first
                            lim_reg  <= (avail == '0) ? pn : avail;
                        end
                        tbce_pkg::ACT_CUT, tbce_pkg::ACT_COPY: begin
                            n_reg    <= take;
                            tail_reg <= avail - take;
                            lim_reg  <= take;
                            clen_reg <= take;
                        end
                        default: begin
                            n_reg    <= '0;
                            tail_reg <= '0;
                            lim_reg  <= '0;
                        end
                    endcase
                end
                tbce_pkg::OP_SHR_WR, tbce_pkg::OP_PST_WR, tbce_pkg::OP_SHL_WR: begin
                    if (i_reg == last_i) begin
                        i_reg <= '0;
                        ph_reg <= 1'b1;
                        lim_reg <= (cmd.op == tbce_pkg::OP_SHR_WR) ? n_reg : lim_reg;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                tbce_pkg::OP_GRAB_WR: begin
                    if (i_reg == last_i) begin
                        i_reg   <= '0;
                        ph_reg  <= 1'b1;
                        lim_reg <= tail_reg;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                tbce_pkg::OP_FINISH: begin
                    case (act_reg)
                        tbce_pkg::ACT_LEFT: begin
                            if (cur_reg != '0) cur_reg <= cur_reg - 1'b1;
                        end
                        tbce_pkg::ACT_RIGHT: begin
                            if (cur_reg < tlen_reg) cur_reg <= cur_reg + 1'b1;
                        end
                        tbce_pkg::ACT_INSERT: begin
                            if (!ovf_reg) begin
                                tlen_reg <= tlen_reg + 1'b1;
                                cur_reg  <= cur_reg + 1'b1;
                            end
                        end
                        tbce_pkg::ACT_PASTE: begin
                            tlen_reg <= tlen_reg + n_reg;
                            cur_reg  <= cur_reg + n_reg;
                        end
                        tbce_pkg::ACT_CUT: tlen_reg <= tlen_reg - n_reg;
                        tbce_pkg::ACT_READ: begin
                            cout_reg <= (32'(pos_reg) < 32'(tlen_reg)) ? rd_reg : 8'd0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        st.action    = act_reg;
        st.loop_done = (i_reg == last_i);
        st.do_shift  = 1'b0;
        st.do_copy   = 1'b0;
        case (act_reg)
            tbce_pkg::ACT_INSERT: begin
                st.do_shift = (tail_reg != '0);
                st.do_copy  = !ovf_reg;
            end
            tbce_pkg::ACT_PASTE: begin
                st.do_shift = (tail_reg != '0);
                st.do_copy  = (n_reg != '0);
            end
            tbce_pkg::ACT_CUT, tbce_pkg::ACT_COPY: begin
                st.do_copy  = (n_reg != '0);
                st.do_shift = (tail_reg != '0) && (n_reg != '0);
            end
            default: ;
        endcase
        if (cmd.op == tbce_pkg::OP_SHL_WR && ph_reg) st.loop_done = (i_reg == last_i);
    end

    assign char_out    = cout_reg;
    assign text_length = 9'(tlen_reg);
    assign cursor_pos  = 9'(cur_reg);
    assign clip_length = 9'(clen_reg);
    assign overflow    = ovf_reg;

endmodule

FILE: design/text_buffer_cursor_editor.sv
// top level of the text buffer cursor editor: controller plus datapath
//
//  channel | ports                                   | direction
//  s_      | s_action s_char_in s_count s_position    | command words in
//  m_      | m_char_out m_text_length m_cursor_pos ... | status words out
//
// sequencing: latch and plan, then a read and a write step per character moved
// through the text/clip memories (insert: tail shift, char write; paste: tail
// shift, clip copy; cut: clip copy, left shift; copy: clip copy), then finish
// reset clears lengths, cursor and control; store contents start undefined
// a pending result stalls the block until taken; one command in flight
module text_buffer_cursor_editor #(
    parameter int TEXT_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_char_in,
    input  logic [8:0] s_count,
    input  logic [7:0] s_position,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic [8:0] m_text_length,
    output logic [8:0] m_cursor_pos,
    output logic [8:0] m_clip_length,
    output logic       m_overflow
);

    tbce_pkg::tbce_cmd_t    cmd;
    tbce_pkg::tbce_status_t st;
    logic busy;

    // accept a word only when the sequencer is idle
    assign s_ready = !busy;

    tbce_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .st        (st),
        .res_taken (m_ready),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (m_valid)
    );

    tbce_datapath #(.TEXT_DEPTH(TEXT_DEPTH)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .action      (s_action),
        .char_in     (s_char_in),
        .count       (s_count),
        .position    (s_position),
        .st          (st),
        .char_out    (m_char_out),
        .text_length (m_text_length),
        .cursor_pos  (m_cursor_pos),
        .clip_length (m_clip_length),
        .overflow    (m_overflow)
    );

`ifndef SYNTHESIS
    // no input taken while a result waits
    a_no_accept_when_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input accepted with result pending");

    // result stays until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

    // cursor never passes text end while a result shows
    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cursor_pos <= m_text_length) else $error("cursor beyond text");
`endif

endmodule
